### design/bus_cycle_address_tracker_core_macros.svh
`ifndef BUS_CYCLE_ADDRESS_TRACKER_CORE_MACROS_SVH
`define BUS_CYCLE_ADDRESS_TRACKER_CORE_MACROS_SVH

// same-cycle implication, off while reset is high
`define BCAT_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bus cycle tracker check failed");

// next-cycle implication, also checked through reset
`define BCAT_ASSERT_NXT(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("bus cycle tracker check failed");

`endif

### design/bcat_pkg.sv
package bcat_pkg;

   localparam logic [7:0] IO_PAGE_HIGH = 8'hFF;

   typedef struct packed {
      logic       addr_strobe;
      logic       read_strobe;
      logic       write_strobe;
      logic [7:0] bus_byte;
   } req_type;

   typedef struct packed {
      logic [15:0] cycle_address;
      logic        is_read;
      logic        is_write;
      logic [7:0]  write_byte;
      logic        dma_grant;
      logic        irq_ack;
      logic        address_loaded;
   } rsp_type;

   typedef struct packed {
      logic [15:0] address_reg;
      logic [7:0]  low_byte_hold;
      logic        prev_addr_strobe;
      logic        load_pending;
   } track_state_type;

endpackage

### design/bcat_cycle_logic.sv
module bcat_cycle_logic (
   input  bcat_pkg::req_type         item,
   input  bcat_pkg::track_state_type cur,
   output bcat_pkg::rsp_type         result,
   output bcat_pkg::track_state_type nxt
);
   import bcat_pkg::*;

   logic is_rd;
   logic is_wr;
   logic load_now;
   logic io_page;
   logic inc;

   always_comb begin
      is_rd    = item.read_strobe && !item.write_strobe;
      is_wr    = item.write_strobe && !item.read_strobe;
      load_now = !cur.load_pending && cur.prev_addr_strobe;
      io_page  = (cur.address_reg[15:8] == IO_PAGE_HIGH);
      inc      = !io_page && !load_now && (is_rd || is_wr);

      nxt                  = cur;
      nxt.load_pending     = load_now;
      nxt.prev_addr_strobe = item.addr_strobe;
      if (load_now) begin
         // high byte from this cycle, low byte from the strobe cycle
         nxt.address_reg = {item.bus_byte, cur.low_byte_hold};
      end else begin
         if (inc) begin
            nxt.address_reg = cur.address_reg + 16'd1;
         end
         nxt.low_byte_hold = item.bus_byte;
      end

      result.cycle_address  = cur.address_reg;
      result.is_read        = is_rd;
      result.is_write       = is_wr;
      result.write_byte     = is_wr ? item.bus_byte : 8'd0;
      result.dma_grant      = item.read_strobe && item.write_strobe && !item.addr_strobe;
      result.irq_ack        = item.read_strobe && item.write_strobe && item.addr_strobe;
      result.address_loaded = load_now;
   end

endmodule

### design/bus_cycle_address_tracker_core.sv
// an accepted req passes the input register and then the result register before rsp_valid rises
// throughput: one bus cycle per clock while rsp_ready stays high
// input register -> decode and address update logic -> result register
// reset (synchronous, active high) empties both registers and clears the
// shadow address, low byte hold, strobe history and pending load to zero
module bus_cycle_address_tracker_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  bcat_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output bcat_pkg::rsp_type rsp_data
);
   import bcat_pkg::*;

   logic            in_valid_ff;
   logic            in_valid_in;
   req_type         in_item_ff;
   logic            out_valid_ff;
   logic            out_valid_in;
   rsp_type         out_data_ff;
   track_state_type state_ff;
   track_state_type state_in;
   rsp_type         result;
   logic            out_free;
   logic            advance;

   bcat_cycle_logic u_cycle_logic (
      .item   (in_item_ff),
      .cur    (state_ff),
      .result (result),
      .nxt    (state_in)
   );

   always_comb begin
      out_free     = !out_valid_ff || rsp_ready;
      advance      = in_valid_ff && out_free;
      req_ready    = !in_valid_ff || advance;
      in_valid_in  = (req_valid && req_ready) || (in_valid_ff && !advance);
      out_valid_in = advance || (out_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         // state moves once per transaction, as it leaves the input register
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_item_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= result;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

### design/bcat_checker.sv
`include "bus_cycle_address_tracker_core_macros.svh"

module bcat_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input bcat_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input bcat_pkg::rsp_type rsp_data
);
   import bcat_pkg::*;

   logic        rsp_fire;
   logic        rsp_wait;
   logic        req_wait;
   logic        rsp_loaded;
   logic        load_fire;
   logic        inc_due;
   logic [15:0] rsp_addr;
   logic [15:0] addr_plus_one;

   assign rsp_fire      = rsp_valid && rsp_ready;
   assign rsp_wait      = rsp_valid && !rsp_ready;
   assign req_wait      = req_valid && !req_ready;
   assign rsp_loaded    = rsp_data.address_loaded;
   assign load_fire     = rsp_fire && rsp_loaded;
   assign rsp_addr      = rsp_data.cycle_address;
   assign addr_plus_one = rsp_data.cycle_address + 16'd1;
   assign inc_due       = rsp_fire && (rsp_data.is_read || rsp_data.is_write) && !rsp_loaded
                          && (rsp_data.cycle_address[15:8] != IO_PAGE_HIGH);

   `BCAT_ASSERT_NXT(a_reset_empty, clock, reset, !rsp_valid)

   `BCAT_ASSERT_NXT(a_rsp_hold, clock, !reset && rsp_wait, rsp_valid && $stable(rsp_data))

   `BCAT_ASSERT_NXT(a_req_hold, clock, !reset && req_wait, req_valid && $stable(req_data))

   // a load cycle is never followed directly by another load
   `BCAT_ASSERT_IMP(a_no_double_load, clock, reset, load_fire ##1 rsp_fire, !rsp_loaded)

   // a read or write outside the i/o page that is not a load cycle moves the address up by one
   `BCAT_ASSERT_IMP(a_increment, clock, reset, inc_due ##1 rsp_fire, rsp_addr == $past(addr_plus_one))

endmodule

bind bus_cycle_address_tracker_core bcat_checker u_bcat_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
